// ===== hdl/rsc_pkg.sv =====
package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DIV_STEPS       = 48;
    localparam int ITER_W          = 16;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REQ_PUSH = 3'd0,
        REQ_ADD  = 3'd1,
        REQ_SUB  = 3'd2,
        REQ_MUL  = 3'd3,
        REQ_DIV  = 3'd4,
        REQ_POW  = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_SAT   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALU,
        S_MUL_P,
        S_MUL_S,
        S_DIV_STEP,
        S_DIV_FIN,
        S_COMMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic alu;
        logic mul_prod;
        logic mul_sat;
        logic div_step;
        logic div_fin;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       few;
        logic       pow_trivial;
        logic       div_zero;
        logic       iter_last;
    } t_dp_stat;

endpackage

// ===== hdl/rsc_ctrl.sv =====
module rsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rsc_pkg::t_dp_stat i_stat,
    output rsc_pkg::t_dp_cmd  o_cmd
);
    import rsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.req == REQ_PUSH || i_stat.req > REQ_POW || i_stat.few) begin
                    n_state = S_COMMIT;
                end else if (i_stat.req == REQ_MUL) begin
                    n_state = S_MUL_P;
                end else if (i_stat.req == REQ_POW) begin
                    n_state = i_stat.pow_trivial ? S_ALU : S_MUL_P;
                end else if (i_stat.req == REQ_DIV) begin
                    n_state = i_stat.div_zero ? S_ALU : S_DIV_STEP;
                end else begin
                    n_state = S_ALU;
                end
            end
            S_ALU:      n_state = S_COMMIT;
            S_MUL_P:    n_state = S_MUL_S;
            S_MUL_S:    n_state = i_stat.iter_last ? S_COMMIT : S_MUL_P;
            S_DIV_STEP: n_state = i_stat.iter_last ? S_DIV_FIN : S_DIV_STEP;
            S_DIV_FIN:  n_state = S_COMMIT;
            S_COMMIT:   n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE:   o_cmd.fetch    = 1'b1;
            S_ALU:      o_cmd.alu      = 1'b1;
            S_MUL_P:    o_cmd.mul_prod = 1'b1;
            S_MUL_S:    o_cmd.mul_sat  = 1'b1;
            S_DIV_STEP: o_cmd.div_step = 1'b1;
            S_DIV_FIN:  o_cmd.div_fin  = 1'b1;
            S_COMMIT:   o_cmd.commit   = 1'b1;
            S_RESP:     o_out_valid    = 1'b1;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

// ===== hdl/rsc_dp.sv =====
module rsc_dp #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsc_pkg::t_dp_cmd  i_cmd,
    output rsc_pkg::t_dp_stat o_stat,
    input  logic [2:0]        i_req_type,
    input  logic [31:0]       i_operand_value,
    output logic [31:0]       o_result_value,
    output logic [31:0]       o_top_value,
    output logic [4:0]        o_stack_depth,
    output logic [2:0]        o_status
);
    import rsc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [31:0]       r_mem [STACK_DEPTH];
    logic [31:0]       r_rd_q;
    logic [CW-1:0]     r_cnt;
    logic [31:0]       r_top;
    logic [2:0]        r_req;
    logic [31:0]       r_val;
    logic signed [31:0] r_lhs, r_rhs, r_acc, r_res;
    logic signed [63:0] r_prod;
    logic [ITER_W-1:0] r_iter;
    logic [31:0]       r_rem, r_dvs;
    logic [47:0]       r_quo;
    logic              r_sat, r_dz;
    logic [31:0]       r_o_res, r_o_top;
    logic [4:0]        r_o_depth;
    logic [2:0]        r_o_status;

    logic [AW-1:0]     rd_addr;
    logic              full, few;
    logic [16:0]       pow_ceil;
    logic [ITER_W-1:0] pow_n;
    logic signed [32:0] sum;
    logic signed [47:0] mul_v;
    logic              mul_ovf;
    logic signed [31:0] mul_q;
    logic [32:0]       div_sh;
    logic              div_ge;
    logic              div_neg;
    logic [CW-1:0]     cnt_new;
    logic [31:0]       cnt_ext;

    assign rd_addr = AW'(r_cnt - CW'(2));
    assign full    = (r_cnt == CW'(STACK_DEPTH));
    assign few     = (r_cnt < CW'(2));

    assign pow_ceil = {1'b0, r_top[31:16]} + {16'd0, |r_top[15:0]};
    assign pow_n    = ITER_W'(pow_ceil - 17'd1);

    // decode happens before the operands are latched: look at the top entry
    assign o_stat.req         = r_req;
    assign o_stat.few         = few;
    assign o_stat.pow_trivial = ($signed(r_top) <= Q_ONE);
    assign o_stat.div_zero    = (r_top == '0);
    assign o_stat.iter_last   = (r_iter == ITER_W'(1));

    // add / subtract
    always_comb begin
        if (r_req == REQ_SUB) begin
            sum = {r_lhs[31], r_lhs} - {r_rhs[31], r_rhs};
        end else begin
            sum = {r_lhs[31], r_lhs} + {r_rhs[31], r_rhs};
        end
    end

    // Q16.16 product, truncated toward zero
    assign mul_v   = r_prod[63:16] + {47'd0, r_prod[63] & (|r_prod[15:0])};
    assign mul_ovf = (mul_v[47:31] != {17{mul_v[31]}});
    assign mul_q   = mul_ovf ? (mul_v[47] ? S32_MIN : S32_MAX) : mul_v[31:0];

    // restoring divide step
    assign div_sh  = {r_rem, r_quo[47]};
    assign div_ge  = (div_sh >= {1'b0, r_dvs});
    assign div_neg = r_lhs[31] ^ r_rhs[31];

    // stack memory
    always_ff @(posedge i_clk) begin
        r_rd_q <= r_mem[rd_addr];
        if (i_cmd.commit) begin
            if (r_req == REQ_PUSH && !full) begin
                r_mem[r_cnt[AW-1:0]] <= r_val;
            end else if (r_req >= REQ_ADD && r_req <= REQ_POW && !few) begin
                r_mem[rd_addr] <= r_res;
            end
        end
    end

    always_comb begin
        cnt_new = r_cnt;
        if (r_req == REQ_PUSH && !full) begin
            cnt_new = r_cnt + CW'(1);
        end else if (r_req >= REQ_ADD && r_req <= REQ_POW && !few) begin
            cnt_new = r_cnt - CW'(1);
        end
    end
    assign cnt_ext = 32'(cnt_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_cnt <= cnt_new;
        end
    end

    // operand and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_val <= i_operand_value;
        end
        if (i_cmd.fetch) begin
            r_lhs <= r_rd_q;
            r_rhs <= r_top;
            r_sat <= 1'b0;
            r_dz  <= 1'b0;
            r_res <= '0;
            r_acc <= (r_req == REQ_POW) ? r_rd_q : r_top;
            priority if (r_req == REQ_POW) begin
                r_iter <= pow_n;
            end else if (r_req == REQ_DIV) begin
                r_iter <= ITER_W'(DIV_STEPS);
            end else begin
                r_iter <= ITER_W'(1);
            end
            r_rem <= '0;
            r_quo <= {(r_rd_q[31] ? 32'(-r_rd_q) : r_rd_q), 16'd0};
            r_dvs <= r_top[31] ? 32'(-r_top) : r_top;
        end
        if (i_cmd.alu) begin
            priority if (r_req == REQ_POW) begin
                r_res <= (r_rhs == '0) ? Q_ONE : r_lhs;
            end else if (r_req == REQ_DIV) begin
                r_dz <= 1'b1;
                priority if (r_lhs == '0) begin
                    r_res <= '0;
                end else if (r_lhs[31]) begin
                    r_res <= S32_MIN;
                end else begin
                    r_res <= S32_MAX;
                end
            end else begin
                if (sum[32] != sum[31]) begin
                    r_sat <= 1'b1;
                    r_res <= sum[32] ? S32_MIN : S32_MAX;
                end else begin
                    r_res <= sum[31:0];
                end
            end
        end
        if (i_cmd.mul_prod) begin
            r_prod <= r_lhs * r_acc;
        end
        if (i_cmd.mul_sat) begin
            r_acc  <= mul_q;
            r_res  <= mul_q;
            r_sat  <= r_sat | mul_ovf;
            r_iter <= r_iter - ITER_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_ge ? 32'(div_sh - {1'b0, r_dvs}) : div_sh[31:0];
            r_quo  <= {r_quo[46:0], div_ge};
            r_iter <= r_iter - ITER_W'(1);
        end
        if (i_cmd.div_fin) begin
            priority if (!div_neg && r_quo > 48'h0000_7FFF_FFFF) begin
                r_sat <= 1'b1;
                r_res <= S32_MAX;
            end else if (div_neg && r_quo > 48'h0000_8000_0000) begin
                r_sat <= 1'b1;
                r_res <= S32_MIN;
            end else begin
                r_res <= div_neg ? 32'(-r_quo[31:0]) : r_quo[31:0];
            end
        end
    end

    // result registers and tracked top of stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_depth <= cnt_ext[4:0];
            priority if (r_req == REQ_PUSH) begin
                if (full) begin
                    r_o_res    <= '0;
                    r_o_top    <= r_top;
                    r_o_status <= ST_FULL;
                end else begin
                    r_top      <= r_val;
                    r_o_res    <= r_val;
                    r_o_top    <= r_val;
                    r_o_status <= ST_OK;
                end
            end else if (r_req > REQ_POW) begin
                r_o_res    <= '0;
                r_o_top    <= (r_cnt == '0) ? '0 : r_top;
                r_o_status <= ST_OK;
            end else if (few) begin
                r_o_res    <= '0;
                r_o_top    <= (r_cnt == '0) ? '0 : r_top;
                r_o_status <= ST_FEW;
            end else begin
                r_top      <= r_res;
                r_o_res    <= r_res;
                r_o_top    <= r_res;
                r_o_status <= r_dz ? ST_DIVZ : (r_sat ? ST_SAT : ST_OK);
            end
        end
    end

    assign o_result_value = r_o_res;
    assign o_top_value    = r_o_top;
    assign o_stack_depth  = r_o_depth;
    assign o_status       = r_o_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_req == REQ_PUSH && full) |=> $stable(r_cnt))
        else $error("refused push changed the stack");

    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_dvs != '0))
        else $error("divide iteration with zero divisor");

endmodule

// ===== hdl/rpn_stack_calculator_top.sv =====
// Operand stack calculator, signed Q16.16. Each input transfer either pushes
// i_operand_value, applies add, subtract, multiply, divide or power to the
// two top entries (second entry is the left operand) or, for the two unused
// codes, changes nothing; exactly one output transfer follows each input
// transfer. One item is processed at a time. Push, too few operands, refused
// push and unused codes go from decode to commit; add, subtract, divide by
// zero and trivial power pass through the ALU step; multiply through the
// product and saturation steps; divide takes one quotient bit per cycle over
// a 48-bit scaled dividend, then a final step; power repeats the product and
// saturation steps ceil(exponent)-1 times through the single 32x32 multiplier
// and its registered saturation stage. The next input transfer can be taken
// in the cycle after the output transfer. Stack entries live in a
// STACK_DEPTH-entry memory with registered read; the top entry is kept in a
// register so only the second entry is read from memory.
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic [31:0] o_top_value,
    output logic [4:0]  o_stack_depth,
    output logic [2:0]  o_status
);
    import rsc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: decode, arithmetic iteration, commit, respond
    rsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // stack memory, multiplier, divider and result registers
    rsc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_operand_value (i_operand_value),
        .o_result_value  (o_result_value),
        .o_top_value     (o_top_value),
        .o_stack_depth   (o_stack_depth),
        .o_status        (o_status)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rsc_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    typedef struct {
        logic [31:0] result;
        logic [31:0] top;
        logic [4:0]  depth;
        t_status     status;
    } t_calc_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_req_type;
    logic [31:0] i_operand_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_result_value;
    logic [31:0] o_top_value;
    logic [4:0]  o_stack_depth;
    logic [2:0]  o_status;

    rpn_stack_calculator_top #(.STACK_DEPTH(DEPTH)) dut (.*);

    // shadow stack of the calculator
    logic signed [31:0] shadow_stack [DEPTH];
    int                 shadow_count;
    t_calc_out          pending_results [$];
    int                 errors;
    bit                 idle_en;
    int                 hold_off_cycles;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [31:0] clamp32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    // Q16.16 multiply, truncating toward zero
    function automatic logic [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b,
                                           inout bit sat);
        longint p;
        p = longint'(a) * longint'(b);
        if (p < 0) return clamp32(-((-p) >>> 16), sat);
        return clamp32(p >>> 16, sat);
    endfunction

    function automatic logic [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b,
                                           inout bit sat, inout bit dz);
        longint ua, ub, q;
        if (b == 0) begin
            dz = 1'b1;
            if (a > 0) return S32_MAX;
            if (a < 0) return S32_MIN;
            return 32'd0;
        end
        ua = (a < 0) ? -longint'(a) : longint'(a);
        ub = (b < 0) ? -longint'(b) : longint'(b);
        q  = (ua <<< 16) / ub;
        return clamp32(((a < 0) != (b < 0)) ? -q : q, sat);
    endfunction

    // repeated multiply: base times itself ceil(e)-1 more times
    function automatic logic [31:0] fx_pow(logic signed [31:0] base, logic signed [31:0] e,
                                           inout bit sat);
        logic signed [31:0] acc;
        longint n;
        acc = base;
        if (e == 0) return Q_ONE;
        if (longint'(e) <= 64'sd65536) return base;
        n = ((longint'(e) + 65535) >>> 16) - 1;
        for (longint k = 0; k < n; k++) acc = fx_mul(base, acc, sat);
        return acc;
    endfunction

    function automatic t_calc_out calc_step(logic [2:0] req, logic [31:0] val);
        t_calc_out o;
        logic signed [31:0] lhs, rhs;
        bit sat, dz;
        o.result = '0;
        o.status = ST_OK;
        sat = 0;
        dz  = 0;
        case (req)
            REQ_PUSH: begin
                if (shadow_count >= DEPTH) o.status = ST_FULL;
                else begin
                    shadow_stack[shadow_count] = val;
                    shadow_count++;
                    o.result = val;
                end
            end
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_POW: begin
                if (shadow_count < 2) o.status = ST_FEW;
                else begin
                    rhs = shadow_stack[shadow_count-1];
                    lhs = shadow_stack[shadow_count-2];
                    case (req)
                        REQ_ADD: o.result = clamp32(longint'(lhs) + longint'(rhs), sat);
                        REQ_SUB: o.result = clamp32(longint'(lhs) - longint'(rhs), sat);
                        REQ_MUL: o.result = fx_mul(lhs, rhs, sat);
                        REQ_DIV: o.result = fx_div(lhs, rhs, sat, dz);
                        default: o.result = fx_pow(lhs, rhs, sat);
                    endcase
                    shadow_count--;
                    shadow_stack[shadow_count-1] = o.result;
                    o.status = dz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
                end
            end
            default: ;  // spare codes do nothing
        endcase
        o.top   = shadow_count ? shadow_stack[shadow_count-1] : '0;
        o.depth = shadow_count[4:0];
        return o;
    endfunction

    // one input transfer; a random gap first when idling is on
    task automatic send_item(logic [2:0] req, logic [31:0] val);
        int gap;
        gap = (idle_en && $urandom_range(4) == 0) ? $urandom_range(1, 7) : 0;
        if (gap) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_operand_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(calc_step(req, val));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge i_clk);
    endtask

    // receiver: check each output transfer, then pick next ready
    initial begin
        int stall;
        t_calc_out want;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_result_value);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result_value !== want.result) begin
                        $display("%0t: result exp %h got %h", $time, want.result,
                                 o_result_value);
                        errors++;
                    end
                    if (o_top_value !== want.top) begin
                        $display("%0t: top exp %h got %h", $time, want.top, o_top_value);
                        errors++;
                    end
                    if (o_stack_depth !== want.depth) begin
                        $display("%0t: depth exp %0d got %0d", $time, want.depth,
                                 o_stack_depth);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, o_status);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(5) == 0) begin
                stall = $urandom_range(1, 7) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {16'(int'($urandom_range(16)) - 8), 16'd0};
            2: return 32'(int'($urandom_range(1 << 18)) - (1 << 17));
            default: return '0;
        endcase
    endfunction

    task automatic test_few_operands();
        send_item(REQ_ADD, 32'd5);
        send_item(REQ_PUSH, Q_ONE);
        send_item(REQ_POW, '0);
        send_item(REQ_SUB, '0);
    endtask

    task automatic test_saturation();
        send_item(REQ_PUSH, S32_MAX);
        send_item(REQ_PUSH, S32_MAX);
        send_item(REQ_ADD, '0);
        send_item(REQ_PUSH, S32_MIN);
        send_item(REQ_SUB, '0);
        send_item(REQ_PUSH, S32_MIN);
        send_item(REQ_MUL, '0);
        send_item(REQ_PUSH, 32'hFFFF_FFFF);
        send_item(REQ_MUL, '0);
    endtask

    task automatic test_divide();
        send_item(REQ_PUSH, 32'h0003_0000);
        send_item(REQ_PUSH, '0);
        send_item(REQ_DIV, '0);
        send_item(REQ_PUSH, S32_MIN);
        send_item(REQ_PUSH, '0);
        send_item(REQ_DIV, '0);
        send_item(REQ_PUSH, '0);
        send_item(REQ_PUSH, '0);
        send_item(REQ_DIV, '0);
        send_item(REQ_PUSH, 32'hFFFF_0000);
        send_item(REQ_DIV, '0);
        send_item(REQ_PUSH, 32'h0000_0001);
        send_item(REQ_DIV, '0);
    endtask

    task automatic test_power();
        send_item(REQ_PUSH, 32'h0002_0000);
        send_item(REQ_PUSH, '0);
        send_item(REQ_POW, '0);
        send_item(REQ_PUSH, 32'hFFFE_0000);
        send_item(REQ_POW, '0);
        send_item(REQ_PUSH, 32'h0002_8000);
        send_item(REQ_POW, '0);
        // exponent at the top of the range: longest run of the block
        send_item(REQ_PUSH, S32_MAX);
        send_item(REQ_POW, '0);
    endtask

    task automatic test_spare_codes();
        send_item(REQ_SPARE6, $urandom);
        send_item(REQ_SPARE7, $urandom);
    endtask

    // receiver held off while the sender waits on it, then a full pause
    task automatic test_backpressure_and_full();
        hold_off_cycles = 400;
        for (int k = 0; k < DEPTH + 3; k++) send_item(REQ_PUSH, $urandom);
        drain_results();
        for (int k = 0; k < DEPTH + 2; k++) send_item(REQ_ADD, '0);
    endtask

    task automatic test_random(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(19);
            if (shadow_count < 2 && r < 16) send_item(REQ_PUSH, rand_value());
            else if (r < 7) send_item(REQ_PUSH, rand_value());
            else if (r < 9) send_item(REQ_ADD, '0);
            else if (r < 11) send_item(REQ_SUB, '0);
            else if (r < 13) send_item(REQ_MUL, '0);
            else if (r < 15) send_item(REQ_DIV, '0);
            else if (r < 18) begin
                // small exponent keeps the power loop short
                send_item(REQ_PUSH, 32'(int'($urandom_range(7 << 16)) - (1 << 16)));
                send_item(REQ_POW, '0);
            end else if (r == 18) send_item(REQ_SPARE6 | 3'($urandom_range(1)), $urandom);
            else begin
                // fill toward the top to hit the full-stack refusal
                repeat ($urandom_range(4, 18)) send_item(REQ_PUSH, rand_value());
            end
        end
    endtask

    initial begin
        errors          = 0;
        idle_en         = 1'b1;
        hold_off_cycles = 0;
        shadow_count    = 0;
        i_in_valid      = 1'b0;
        i_req_type      = REQ_PUSH;
        i_operand_value = '0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_few_operands();
        test_saturation();
        test_divide();
        test_power();
        test_spare_codes();
        test_backpressure_and_full();
        test_random(430);
        idle_en = 1'b0;
        test_random(100);
        drain_results();
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
